// File: src/assert_macros.svh
// Assertion macros used by the checker file m3i_checker.sv.
// Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
package m3i_pkg;

  localparam int NLANE  = 9;   // inverse entries
  localparam int QW     = 32;  // quotient width
  localparam int DW     = 48;  // |det| width
  localparam int NDIV   = 32;  // divider steps, one quotient bit each
  localparam int NFRONT = 4;   // cofactor / determinant stages
  localparam int NSTG   = NFRONT + NDIV + 1;

  localparam logic [QW-1:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q16_MIN = 32'h8000_0000;

  // cofactor operand indices (row-major flat index of the input matrix),
  // adj = m[PA0]*m[PA1] - m[PB0]*m[PB1]
  localparam int PA0 [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PA1 [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PB0 [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PB1 [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic [DW-1:0] p;    // partial remainder, below d while in range
    logic [QW-1:0] w;    // dividend bits out the top, quotient bits in
    logic          neg;  // quotient sign
    logic          ovf;  // magnitude at least 2^32
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic  [DW-1:0]    d;
    logic              sing;
  } div_t;

endpackage

// File: src/m3i_front.sv
// Cofactor products, cofactors, determinant and divider setup: 4 stages.
// Depends on m3i_pkg.
module m3i_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [m3i_pkg::NFRONT-1:0]       en,
  input  logic                             iv,
  input  logic [m3i_pkg::NLANE-1:0][15:0]  a,
  output logic [m3i_pkg::NFRONT-1:0]       v,
  output m3i_pkg::div_t                    od
);

  logic signed [31:0] pa [m3i_pkg::NLANE];
  logic signed [31:0] pb [m3i_pkg::NLANE];
  logic signed [15:0] r1 [3];
  logic signed [32:0] adj2 [m3i_pkg::NLANE];
  logic signed [15:0] r2 [3];
  logic signed [32:0] adj3 [m3i_pkg::NLANE];
  logic signed [48:0] dp [3];
  logic signed [50:0] det;
  logic [49:0]        dabs;
  m3i_pkg::div_t      s4_next;

  // stage 1: 2x2 products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < m3i_pkg::NLANE; i++) begin
        pa[i] <= $signed(a[m3i_pkg::PA0[i]]) * $signed(a[m3i_pkg::PA1[i]]);
        pb[i] <= $signed(a[m3i_pkg::PB0[i]]) * $signed(a[m3i_pkg::PB1[i]]);
      end
      for (int i = 0; i < 3; i++) r1[i] <= $signed(a[i]);
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < m3i_pkg::NLANE; i++) begin
        adj2[i] <= 33'(pa[i]) - 33'(pb[i]);
      end
      r2 <= r1;
    end
  end

  // stage 3: determinant terms along row 0
  always_ff @(posedge clk) begin
    if (en[2]) begin
      adj3  <= adj2;
      dp[0] <= r2[0] * adj2[0];
      dp[1] <= r2[1] * adj2[3];
      dp[2] <= r2[2] * adj2[6];
    end
  end

  // stage 4: magnitudes, signs, overflow precheck
  always_comb begin
    logic [32:0] cabs;
    det  = 51'(dp[0]) + 51'(dp[1]) + 51'(dp[2]);
    dabs = det[50] ? 50'(-det) : det[49:0];
    s4_next.d    = dabs[m3i_pkg::DW-1:0];
    s4_next.sing = (det == '0);
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      cabs = adj3[i][32] ? 33'(-adj3[i]) : adj3[i];
      s4_next.lane[i].neg = adj3[i][32] ^ det[50];
      // quotient of 2^32 or more exactly when |cof| >= 16*|det|
      s4_next.lane[i].ovf = {20'b0, cabs[31:0]} >= {dabs[m3i_pkg::DW-1:0], 4'b0};
      s4_next.lane[i].p   = {20'b0, cabs[31:4]};
      s4_next.lane[i].w   = {cabs[3:0], 28'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) od <= s4_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= iv;
      for (int i = 1; i < m3i_pkg::NFRONT; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

endmodule

// File: src/m3i_div_step.sv
// One restoring division step for all nine lanes: one quotient bit each.
// Depends on m3i_pkg.
module m3i_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          iv,
  input  m3i_pkg::div_t id,
  output logic          ov,
  output m3i_pkg::div_t od
);

  m3i_pkg::div_t nxt;

  always_comb begin
    logic [m3i_pkg::DW:0] p2;
    logic                 q;
    nxt = id;
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      p2 = {id.lane[i].p, id.lane[i].w[m3i_pkg::QW-1]};
      q  = p2 >= {1'b0, id.d};
      nxt.lane[i].p = q ? m3i_pkg::DW'(p2 - {1'b0, id.d}) : p2[m3i_pkg::DW-1:0];
      nxt.lane[i].w = {id.lane[i].w[m3i_pkg::QW-2:0], q};
    end
  end

  always_ff @(posedge clk) begin
    if (en) od <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= iv;
    end
  end

endmodule

// File: src/m3i_out.sv
// Sign, saturation and singular override; output register.
// Depends on m3i_pkg.
module m3i_out (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      iv,
  input  m3i_pkg::div_t                             id,
  output logic                                      ov,
  output logic [m3i_pkg::NLANE-1:0][m3i_pkg::QW-1:0] inv,
  output logic                                      sing
);

  logic [m3i_pkg::NLANE-1:0][m3i_pkg::QW-1:0] inv_next;

  always_comb begin
    logic [m3i_pkg::QW-1:0] mag;
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      mag = id.lane[i].w;
      if (id.sing) begin
        inv_next[i] = m3i_pkg::Q16_MAX;
      end else if (id.lane[i].neg) begin
        inv_next[i] = (id.lane[i].ovf || mag > m3i_pkg::Q16_MIN) ?
                      m3i_pkg::Q16_MIN : m3i_pkg::QW'(-mag);
      end else begin
        inv_next[i] = (id.lane[i].ovf || mag[m3i_pkg::QW-1]) ? m3i_pkg::Q16_MAX : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv  <= inv_next;
      sing <= id.sing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= iv;
    end
  end

endmodule

// File: src/matrix3x3_inverse_unit.sv
// Top level of the 3x3 matrix inverse (adjugate / determinant) pipeline.
// Depends on m3i_pkg, m3i_front, m3i_div_step, m3i_out.
//
// Usage:
//  - Input channel: in_valid / in_stall with the nine Q4.12 entries a00..a22.
//    An item is taken at a clock edge with in_valid high and in_stall low.
//  - Output channel: out_valid / out_stall with inv00..inv22 (Q16.16,
//    saturated) and singular. A result moves when out_valid && !out_stall.
//  - The pipeline has 4 cofactor/determinant stages, 32 divider stages
//    (one quotient bit per stage, all nine entries in parallel, one 49-bit
//    compare-subtract per lane) and the output register.
//  - Throughput is one item per cycle while out_stall is low; fully pipelined.
//  - Each stage carries its own valid bit and loads whenever it is empty or
//    the stage after it moves, so bubbles close up under a stall and the
//    block keeps accepting items while a result waits at the output.
//  - When out_stall holds, the output register and its payload hold; stages
//    fill up behind it and in_stall rises once the whole pipeline is full.
//  - A zero determinant gives 0x7FFFFFFF in every entry with singular set.
//  - Reset (rst, synchronous) clears all valid bits; in flight items are
//    dropped. Payload registers are not reset.
module matrix3x3_inverse_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] a00,
  input  logic [15:0] a01,
  input  logic [15:0] a02,
  input  logic [15:0] a10,
  input  logic [15:0] a11,
  input  logic [15:0] a12,
  input  logic [15:0] a20,
  input  logic [15:0] a21,
  input  logic [15:0] a22,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] inv00,
  output logic [31:0] inv01,
  output logic [31:0] inv02,
  output logic [31:0] inv10,
  output logic [31:0] inv11,
  output logic [31:0] inv12,
  output logic [31:0] inv20,
  output logic [31:0] inv21,
  output logic [31:0] inv22,
  output logic        singular
);

  // valid and load enable of every stage, input side first
  logic [m3i_pkg::NSTG-1:0] v;
  logic [m3i_pkg::NSTG-1:0] en;

  // data between divider stages; dd[0] comes from the front end
  m3i_pkg::div_t dd [m3i_pkg::NDIV+1];

  logic [m3i_pkg::NLANE-1:0][15:0]             a;
  logic [m3i_pkg::NLANE-1:0][m3i_pkg::QW-1:0]  inv;

  assign a = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  // a stage loads when it is empty or its successor moves on
  assign en[m3i_pkg::NSTG-1] = !v[m3i_pkg::NSTG-1] || !out_stall;
  for (genvar i = 0; i < m3i_pkg::NSTG - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign in_stall = !en[0];

  m3i_front u_front (
    .clk (clk),
    .rst (rst),
    .en  (en[m3i_pkg::NFRONT-1:0]),
    .iv  (in_valid),
    .a   (a),
    .v   (v[m3i_pkg::NFRONT-1:0]),
    .od  (dd[0])
  );

  for (genvar k = 0; k < m3i_pkg::NDIV; k++) begin : g_div
    m3i_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en[m3i_pkg::NFRONT+k]),
      .iv  (v[m3i_pkg::NFRONT+k-1]),
      .id  (dd[k]),
      .ov  (v[m3i_pkg::NFRONT+k]),
      .od  (dd[k+1])
    );
  end

  m3i_out u_out (
    .clk  (clk),
    .rst  (rst),
    .en   (en[m3i_pkg::NSTG-1]),
    .iv   (v[m3i_pkg::NSTG-2]),
    .id   (dd[m3i_pkg::NDIV]),
    .ov   (v[m3i_pkg::NSTG-1]),
    .inv  (inv),
    .sing (singular)
  );

  assign out_valid = v[m3i_pkg::NSTG-1];
  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

endmodule

// File: src/m3i_checker.sv
// Port-level checks for matrix3x3_inverse_unit, bound to the top level.
// Depends on assert_macros.svh and m3i_pkg.
`include "assert_macros.svh"

module m3i_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
  input logic        singular
);

  logic all_max;
  assign all_max = inv00 == m3i_pkg::Q16_MAX && inv01 == m3i_pkg::Q16_MAX &&
                   inv02 == m3i_pkg::Q16_MAX && inv10 == m3i_pkg::Q16_MAX &&
                   inv11 == m3i_pkg::Q16_MAX && inv12 == m3i_pkg::Q16_MAX &&
                   inv20 == m3i_pkg::Q16_MAX && inv21 == m3i_pkg::Q16_MAX &&
                   inv22 == m3i_pkg::Q16_MAX;

  // a singular result carries the maximum in every entry
  `ASSERT_IMPL(a_sing_max, out_valid && singular, all_max)
  // empty output register means the whole pipeline can advance
  `ASSERT_IMPL(a_no_stall_empty, !out_valid, !in_stall)
  // nothing comes out right after reset
  `ASSERT_IMPL(a_reset_clear, $past(rst), !out_valid)
  // a stalled result holds
  `ASSERT_NEXT(a_hold, out_valid && out_stall,
               out_valid && $stable(inv00) && $stable(inv22) && $stable(singular))

endmodule

bind matrix3x3_inverse_unit m3i_checker u_m3i_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for matrix3x3_inverse_unit: the adjugate 3x3 inverse in Q16.16.
// Depends on m3i_pkg and the RTL; drives directed and random matrices and
// checks every result against a built-in exact-integer inverse predictor.
module tb;

  localparam int LATENCY   = 37;
  localparam int N_RANDOM  = 630;
  localparam longint LIMIT = 400000;

  // one matrix and one inverse
  typedef logic [15:0] mat_t [9];
  typedef struct {
    logic [31:0] e [9];
    logic        sing;
  } inv_t;

  // directed row: matrix, and an inverse typed in where it is obvious
  typedef struct {
    mat_t m;
    bit   known;
    inv_t r;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] a [9];
  logic        out_valid;
  logic        out_stall;
  logic [31:0] q [9];
  logic        singular;

  inv_t   pending_inv [$];
  int     mismatches;
  int     n_items;
  int     n_results;
  int     n_singular;
  int     n_sat;
  int     phase;
  longint cycles = 0;

  matrix3x3_inverse_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a00(a[0]), .a01(a[1]), .a02(a[2]),
    .a10(a[3]), .a11(a[4]), .a12(a[5]),
    .a20(a[6]), .a21(a[7]), .a22(a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv00(q[0]), .inv01(q[1]), .inv02(q[2]),
    .inv10(q[3]), .inv11(q[4]), .inv12(q[5]),
    .inv20(q[6]), .inv21(q[7]), .inv22(q[8]),
    .singular(singular)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact inverse: cofactors over the determinant, scaled by 2^28, truncated
  // toward zero and clamped to Q16.16. Zero determinant gives all-max.
  function automatic inv_t invert(mat_t m);
    longint  v [9];
    longint  adj [9];
    longint  det;
    longint  num;
    longint  qq;
    inv_t    r;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(m[i]));
    det = v[0]*v[4]*v[8] + v[1]*v[5]*v[6] + v[2]*v[3]*v[7]
        - v[2]*v[4]*v[6] - v[1]*v[3]*v[8] - v[0]*v[5]*v[7];
    r.sing = (det == 0);
    if (r.sing) begin
      for (int i = 0; i < 9; i++) r.e[i] = m3i_pkg::Q16_MAX;
      return r;
    end
    // adjugate, row-major (transpose of cofactors)
    adj[0] =   v[4]*v[8] - v[5]*v[7];
    adj[3] = -(v[3]*v[8] - v[5]*v[6]);
    adj[6] =   v[3]*v[7] - v[4]*v[6];
    adj[1] = -(v[1]*v[8] - v[2]*v[7]);
    adj[4] =   v[0]*v[8] - v[2]*v[6];
    adj[7] = -(v[0]*v[7] - v[1]*v[6]);
    adj[2] =   v[1]*v[5] - v[2]*v[4];
    adj[5] = -(v[0]*v[5] - v[2]*v[3]);
    adj[8] =   v[0]*v[4] - v[1]*v[3];
    for (int i = 0; i < 9; i++) begin
      // |adj| < 2^31 so adj * 2^28 fits in 64 bits; SV division truncates
      num = adj[i] * 64'sd268435456;
      qq  = num / det;
      if (qq > 64'sd2147483647)       r.e[i] = m3i_pkg::Q16_MAX;
      else if (qq < -64'sd2147483648) r.e[i] = m3i_pkg::Q16_MIN;
      else                            r.e[i] = qq[31:0];
    end
    return r;
  endfunction

  function automatic bit same_inv(inv_t x, inv_t y);
    bit ok;
    ok = (x.sing === y.sing);
    foreach (x.e[i]) if (x.e[i] !== y.e[i]) ok = 1'b0;
    return ok;
  endfunction

  function automatic mat_t diag(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
    mat_t m;
    foreach (m[i]) m[i] = 16'h0000;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  function automatic mat_t fill(logic [15:0] x);
    mat_t m;
    foreach (m[i]) m[i] = x;
    return m;
  endfunction

  function automatic inv_t all_max();
    inv_t r;
    foreach (r.e[i]) r.e[i] = m3i_pkg::Q16_MAX;
    r.sing = 1'b1;
    return r;
  endfunction

  function automatic inv_t diag_inv(logic [31:0] d);
    inv_t r;
    foreach (r.e[i]) r.e[i] = 32'h0;
    r.e[0] = d;
    r.e[4] = d;
    r.e[8] = d;
    r.sing = 1'b0;
    return r;
  endfunction

  // Random matrix; small entries now and then so quotients land in range,
  // near-singular rows sometimes to push saturation, exact singular too.
  function automatic mat_t rand_matrix();
    mat_t m;
    int   kind;
    kind = $urandom_range(0, 9);
    foreach (m[i]) begin
      case (kind)
        0, 1, 2: m[i] = 16'($urandom);
        3, 4:    m[i] = 16'($signed($urandom_range(0, 16383)) - 8192);
        5:       m[i] = 16'($signed($urandom_range(0, 15)) - 8);
        default: m[i] = 16'($signed($urandom_range(0, 131071)) - 65536);
      endcase
    end
    if (kind == 6) begin
      // repeated row: singular
      m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
    end else if (kind == 7) begin
      // almost repeated row: tiny determinant, large quotients
      m[6] = m[0]; m[7] = m[1]; m[8] = m[2] + 16'd1;
    end
    return m;
  endfunction

  // Present one matrix and hold it until taken; valid drops only while idling.
  task automatic send_matrix(mat_t m);
    while (phase == 0 && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (phase == 1 && $urandom_range(0, 99) < 71) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    foreach (a[i]) a[i] <= m[i];
    in_valid <= 1'b1;
    pending_inv.push_back(invert(m));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  // Receiver stall pattern, by phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase == 0) begin
      out_stall <= ($urandom_range(0, 99) < 71);
    end else if (phase == 1) begin
      out_stall <= ($urandom_range(0, 99) < 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    inv_t want;
    bit   bad;
    if (!rst && out_valid && !out_stall) begin
      if (pending_inv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with nothing expected");
      end else begin
        want = pending_inv.pop_front();
        bad = (singular !== want.sing);
        foreach (q[i]) if (q[i] !== want.e[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch at result %0d, singular exp %0b got %0b",
                     n_results, want.sing, singular);
            foreach (q[i])
              $display("  inv[%0d] exp %h got %h", i, want.e[i], q[i]);
          end
        end
        if (want.sing) n_singular++;
        foreach (want.e[i])
          if (!want.sing && (want.e[i] == m3i_pkg::Q16_MAX ||
                             want.e[i] == m3i_pkg::Q16_MIN))
            n_sat++;
      end
      n_results++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    int   wait_cycles;
    mismatches   = 0;
    n_items      = 0;
    n_results    = 0;
    n_singular   = 0;
    n_sat        = 0;
    phase        = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    foreach (a[i]) a[i] = 16'h0;

    // directed rows
    rw.known = 1; rw.m = fill(16'h0000);      rw.r = all_max();           rows.push_back(rw);
    rw.known = 1; rw.m = fill(16'h7FFF);      rw.r = all_max();           rows.push_back(rw);
    rw.known = 1; rw.m = fill(16'h8000);      rw.r = all_max();           rows.push_back(rw);
    rw.known = 1; rw.m = fill(16'hFFFF);      rw.r = all_max();           rows.push_back(rw);
    // identity: 1.0 in Q4.12 inverts to 1.0 in Q16.16
    rw.known = 1; rw.m = diag(16'h1000, 16'h1000, 16'h1000);
    rw.r = diag_inv(32'h0001_0000); rows.push_back(rw);
    // 2.0 on the diagonal gives 0.5
    rw.known = 1; rw.m = diag(16'h2000, 16'h2000, 16'h2000);
    rw.r = diag_inv(32'h0000_8000); rows.push_back(rw);
    // -1.0 on the diagonal gives -1.0
    rw.known = 1; rw.m = diag(16'hF000, 16'hF000, 16'hF000);
    rw.r = diag_inv(32'hFFFF_0000); rows.push_back(rw);
    // smallest positive step: 1/2^-12 = 4096.0, still inside Q16.16
    rw.known = 1; rw.m = diag(16'h0001, 16'h0001, 16'h0001);
    rw.r = diag_inv(32'h1000_0000); rows.push_back(rw);
    // smallest negative step gives -4096.0
    rw.known = 1; rw.m = diag(16'hFFFF, 16'hFFFF, 16'hFFFF);
    rw.r = diag_inv(32'hF000_0000); rows.push_back(rw);
    // single zero on diagonal: singular
    rw.known = 1; rw.m = diag(16'h1000, 16'h0000, 16'h1000);
    rw.r = all_max(); rows.push_back(rw);
    // extremes mixed on the diagonal and elsewhere, predictor-checked
    rw.known = 0; rw.m = diag(16'h7FFF, 16'h8000, 16'h7FFF); rows.push_back(rw);
    rw.known = 0; rw.m = diag(16'h8000, 16'h8000, 16'h8000); rows.push_back(rw);
    rw.known = 0; rw.m = diag(16'h7FFF, 16'h7FFF, 16'h7FFF); rows.push_back(rw);
    rw.known = 0;
    rw.m = '{16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
             16'h0001, 16'hFFFF, 16'h7FFF};
    rows.push_back(rw);
    rw.m = '{16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h1000, 16'h4000,
             16'h5000, 16'h6000, 16'h0000};
    rows.push_back(rw);
    rw.m = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
             16'h7FFF, 16'h7FFF, 16'h8000};
    rows.push_back(rw);
    rw.m = '{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC,
             16'h00FF, 16'hFF00, 16'h1234};
    rows.push_back(rw);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      // typed-in answer must agree with the predictor's
      if (rows[k].known && !same_inv(invert(rows[k].m), rows[k].r)) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: directed row %0d prediction disagrees", k);
      end
      send_matrix(rows[k].m);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) phase = 1;
      if (k == 2 * N_RANDOM / 3) phase = 2;
      send_matrix(rand_matrix());
    end
    in_valid <= 1'b0;

    while (pending_inv.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 2 * LATENCY && !(out_valid && !out_stall)) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2) @(posedge clk);

    $display("tb: %0d matrices sent, %0d inverses checked, %0d singular, %0d clamped entries",
             n_items, n_results, n_singular, n_sat);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
